@@ rtl/thumb_alu_execute_macros.svh @@
// assertion helpers shared by the execute stage
`ifndef THUMB_ALU_EXECUTE_MACROS_SVH
`define THUMB_ALU_EXECUTE_MACROS_SVH

// property checked on every clock outside reset
`define TAE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies property in the next
`define TAE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/tae_pkg.sv @@
`timescale 1ns / 1ps

package tae_pkg;

  // opcode field values that select a format
  localparam logic [2:0] FMT_SHIFT_ADDSUB = 3'b000;
  localparam logic [2:0] FMT_IMM8         = 3'b001;
  localparam logic [5:0] FMT_ALU          = 6'b010000;
  localparam logic [1:0] SHIFT_ADDSUB     = 2'b11;

  // format 3 sub-operations
  typedef enum logic [1:0] {
    IMM_MOV = 2'd0,
    IMM_CMP = 2'd1,
    IMM_ADD = 2'd2,
    IMM_SUB = 2'd3
  } imm_op_t;

  // shift kinds, format 1 encoding
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // format 4 operations
  typedef enum logic [3:0] {
    ALU_AND = 4'h0,
    ALU_EOR = 4'h1,
    ALU_LSL = 4'h2,
    ALU_LSR = 4'h3,
    ALU_ASR = 4'h4,
    ALU_ADC = 4'h5,
    ALU_SBC = 4'h6,
    ALU_ROR = 4'h7,
    ALU_TST = 4'h8,
    ALU_NEG = 4'h9,
    ALU_CMP = 4'hA,
    ALU_CMN = 4'hB,
    ALU_ORR = 4'hC,
    ALU_MUL = 4'hD,
    ALU_BIC = 4'hE,
    ALU_MVN = 4'hF
  } alu_op_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // one input item as held in the operand stage
  typedef struct packed {
    logic        kind;
    logic [15:0] instruction;
    logic [2:0]  reg_index;
    logic [31:0] write_value;
  } item_t;

  typedef struct packed {
    logic [2:0]  dest_index;
    logic [31:0] dest_value;
    logic        reg_written;
    flags_t      flags;
    logic        not_handled;
  } alu_result_t;

  // first register operand: Rs for formats 1/2, Rd otherwise
  function automatic logic [2:0] read_addr_a(input logic [15:0] op);
    if (op[15:13] == FMT_SHIFT_ADDSUB) begin
      return op[5:3];
    end else if (op[15:13] == FMT_IMM8) begin
      return op[10:8];
    end
    return op[2:0];
  endfunction

  // second register operand: Rn for format 2, Rs for format 4
  function automatic logic [2:0] read_addr_b(input logic [15:0] op);
    if (op[15:13] == FMT_SHIFT_ADDSUB) begin
      return op[8:6];
    end
    return op[5:3];
  endfunction

endpackage

@@ rtl/tae_alu.sv @@
`timescale 1ns / 1ps

module tae_alu (
  input  tae_pkg::item_t       item,
  input  logic [31:0]          op_a,
  input  logic [31:0]          op_b,
  input  tae_pkg::flags_t      flags_in,
  output tae_pkg::alu_result_t result
);
  import tae_pkg::*;

  // a + b + cin, returns {carry, overflow, sum}
  function automatic logic [33:0] add_flags(input logic [31:0] a, input logic [31:0] b,
                                            input logic cin);
    logic [32:0] s;
    logic        ovf;
    s   = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    ovf = (s[31] ^ a[31]) & (s[31] ^ b[31]);
    return {s[32], ovf, s[31:0]};
  endfunction

  // barrel shift, returns {carry, value}; zero amount keeps value and carry
  function automatic logic [32:0] shift_op(input shift_t kind, input logic [31:0] v,
                                           input logic [7:0] n, input logic cin);
    logic [32:0]        t;
    logic signed [32:0] sa;
    logic [63:0]        rr;
    t  = {cin, v};
    sa = '0;
    rr = '0;
    if (n != 8'd0) begin
      unique case (kind)
        SH_LSL: t = {1'b0, v} << n;
        SH_LSR: begin
          sa = $signed({v, 1'b0} >> n);
          t  = {sa[0], sa[32:1]};
        end
        SH_ASR: begin
          sa = $signed({v, 1'b0}) >>> n;
          t  = {sa[0], sa[32:1]};
        end
        SH_ROR: begin
          rr = {v, v} >> n[4:0];
          t  = {rr[31], rr[31:0]};
        end
      endcase
    end
    return t;
  endfunction

  logic [15:0] op;
  logic [31:0] imm8;
  logic [31:0] add_b;
  logic [7:0]  sh_amt;
  logic [33:0] ad;
  logic [32:0] sh;
  logic [31:0] prod;
  alu_op_t     alu_op;

  assign op     = item.instruction;
  assign imm8   = {24'd0, op[7:0]};
  assign alu_op = alu_op_t'(op[9:6]);

  // low half of the product for MUL
  assign prod = op_a * op_b;

  // adder and shifter functions used by formats 1 to 4
  always_comb begin
    add_b  = op_b;
    sh_amt = op_b[7:0];
    ad     = '0;
    sh     = '0;
    result = '0;
    result.flags = flags_in;

    if (item.kind) begin
      // direct register write, flags kept
      result.dest_index  = item.reg_index;
      result.dest_value  = item.write_value;
      result.reg_written = 1'b1;
    end else if (op[15:13] == FMT_SHIFT_ADDSUB) begin
      result.dest_index  = op[2:0];
      result.reg_written = 1'b1;
      if (op[12:11] == SHIFT_ADDSUB) begin
        add_b = op[10] ? {29'd0, op[8:6]} : op_b;
        ad    = op[9] ? add_flags(op_a, ~add_b, 1'b1) : add_flags(op_a, add_b, 1'b0);
        result.dest_value = ad[31:0];
        result.flags.c    = ad[33];
        result.flags.v    = ad[32];
      end else begin
        // shift by immediate, zero means 32 for right shifts
        sh_amt = {3'd0, op[10:6]};
        if (op[12:11] != SH_LSL && op[10:6] == 5'd0) begin
          sh_amt = 8'd32;
        end
        sh = shift_op(shift_t'(op[12:11]), op_a, sh_amt, flags_in.c);
        result.dest_value = sh[31:0];
        result.flags.c    = sh[32];
      end
      result.flags.n = result.dest_value[31];
      result.flags.z = (result.dest_value == 32'd0);
    end else if (op[15:13] == FMT_IMM8) begin
      result.dest_index = op[10:8];
      unique case (imm_op_t'(op[12:11]))
        IMM_MOV: begin
          result.dest_value  = imm8;
          result.reg_written = 1'b1;
        end
        IMM_CMP: begin
          ad = add_flags(op_a, ~imm8, 1'b1);
          result.dest_value = op_a;
        end
        IMM_ADD: begin
          ad = add_flags(op_a, imm8, 1'b0);
          result.dest_value  = ad[31:0];
          result.reg_written = 1'b1;
        end
        IMM_SUB: begin
          ad = add_flags(op_a, ~imm8, 1'b1);
          result.dest_value  = ad[31:0];
          result.reg_written = 1'b1;
        end
      endcase
      if (op[12:11] == IMM_MOV) begin
        result.flags.n = imm8[31];
        result.flags.z = (imm8 == 32'd0);
      end else begin
        result.flags.n = ad[31];
        result.flags.z = (ad[31:0] == 32'd0);
        result.flags.c = ad[33];
        result.flags.v = ad[32];
      end
    end else if (op[15:10] == FMT_ALU) begin
      result.dest_index  = op[2:0];
      result.dest_value  = op_a;
      result.reg_written = 1'b1;
      unique case (alu_op)
        ALU_AND: result.dest_value = op_a & op_b;
        ALU_EOR: result.dest_value = op_a ^ op_b;
        ALU_LSL: sh = shift_op(SH_LSL, op_a, sh_amt, flags_in.c);
        ALU_LSR: sh = shift_op(SH_LSR, op_a, sh_amt, flags_in.c);
        ALU_ASR: sh = shift_op(SH_ASR, op_a, sh_amt, flags_in.c);
        ALU_ADC: ad = add_flags(op_a, op_b, flags_in.c);
        ALU_SBC: ad = add_flags(op_a, ~op_b, flags_in.c);
        ALU_ROR: sh = shift_op(SH_ROR, op_a, sh_amt, flags_in.c);
        ALU_TST: result.reg_written = 1'b0;
        ALU_NEG: ad = add_flags(32'd0, ~op_b, 1'b1);
        ALU_CMP: begin
          ad = add_flags(op_a, ~op_b, 1'b1);
          result.reg_written = 1'b0;
        end
        ALU_CMN: begin
          ad = add_flags(op_a, op_b, 1'b0);
          result.reg_written = 1'b0;
        end
        ALU_ORR: result.dest_value = op_a | op_b;
        ALU_MUL: result.dest_value = prod;
        ALU_BIC: result.dest_value = op_a & ~op_b;
        ALU_MVN: result.dest_value = ~op_b;
      endcase

      // flag update by operation class
      if (alu_op == ALU_LSL || alu_op == ALU_LSR || alu_op == ALU_ASR ||
          alu_op == ALU_ROR) begin
        result.dest_value = sh[31:0];
        result.flags.c    = sh[32];
        result.flags.n    = sh[31];
        result.flags.z    = (sh[31:0] == 32'd0);
      end else if (alu_op == ALU_ADC || alu_op == ALU_SBC || alu_op == ALU_NEG ||
                   alu_op == ALU_CMP || alu_op == ALU_CMN) begin
        if (result.reg_written) begin
          result.dest_value = ad[31:0];
        end
        result.flags.n = ad[31];
        result.flags.z = (ad[31:0] == 32'd0);
        result.flags.c = ad[33];
        result.flags.v = ad[32];
      end else if (alu_op == ALU_TST) begin
        result.flags.n = op_a[31] & op_b[31];
        result.flags.z = ((op_a & op_b) == 32'd0);
      end else begin
        result.flags.n = result.dest_value[31];
        result.flags.z = (result.dest_value == 32'd0);
      end
    end else begin
      // memory, branch, high-register and other formats
      result.not_handled = 1'b1;
    end
  end

endmodule

@@ rtl/thumb_alu_execute.sv @@
`timescale 1ns / 1ps
// Thumb data-processing execute stage, formats 1 to 4.
// Input channel: in_valid / in_stall with in_kind, in_instruction, in_reg_index and
// in_write_value. Kind 0 executes the opcode, kind 1 writes in_reg_index directly.
// Result channel: out_valid / out_stall with destination register, its value, the
// write flag, the N Z C V flags after the item and the not-handled flag.
// Every accepted item yields exactly one result, in order.
// Each item passes through two registers, the operand stage and then the result stage,
// before it is presented on the result ports.
// Throughput: one item per cycle while the receiver does not stall. The register file
// is read when an item enters the operand stage, with a bypass from the write done by
// the item leaving it at the same edge; the ALU is combinational and the register write
// and flag update take effect as the item leaves. When the receiver stalls, the result
// is held; the operand stage then fills and in_stall rises until the result is taken.
// Reset clears all eight registers (valid bits cleared at once) and the flags,
// and empties both stages; the block accepts items in the first cycle after it.
`include "thumb_alu_execute_macros.svh"

module thumb_alu_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_instruction,
  input  logic [2:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic        out_reg_written,
  output logic        out_flag_n,
  output logic        out_flag_z,
  output logic        out_flag_c,
  output logic        out_flag_v,
  output logic        out_not_handled
);
  import tae_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  item_t       s1_item_r;
  logic [31:0] s1_a_r;
  logic [31:0] s1_b_r;

  logic [31:0] rf_mem_r [8];
  logic [7:0]  rf_valid_r;

  flags_t      flags_r;
  alu_result_t alu_res;
  alu_result_t out_res_r;
  logic        out_valid_r, out_valid_nxt;

  logic        advance;
  logic        in_xfer;
  logic        out_xfer;
  logic        wr_en;
  logic [2:0]  rd_a;
  logic [2:0]  rd_b;

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !(!out_valid_r || !out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  assign rd_a  = read_addr_a(in_instruction);
  assign rd_b  = read_addr_b(in_instruction);
  assign wr_en = advance && alu_res.reg_written;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_xfer ? 1'b0 : out_valid_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      rf_valid_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        flags_r <= alu_res.flags;
      end
      if (wr_en) begin
        rf_valid_r[alu_res.dest_index] <= 1'b1;
      end
    end
  end

  // register file write and operand read with bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem_r[alu_res.dest_index] <= alu_res.dest_value;
    end
    if (in_xfer) begin
      s1_item_r <= '{kind: in_kind, instruction: in_instruction,
                     reg_index: in_reg_index, write_value: in_write_value};
      if (wr_en && alu_res.dest_index == rd_a) begin
        s1_a_r <= alu_res.dest_value;
      end else if (rf_valid_r[rd_a]) begin
        s1_a_r <= rf_mem_r[rd_a];
      end else begin
        s1_a_r <= '0;
      end
      if (wr_en && alu_res.dest_index == rd_b) begin
        s1_b_r <= alu_res.dest_value;
      end else if (rf_valid_r[rd_b]) begin
        s1_b_r <= rf_mem_r[rd_b];
      end else begin
        s1_b_r <= '0;
      end
    end
  end

  tae_alu u_alu (
    .item     (s1_item_r),
    .op_a     (s1_a_r),
    .op_b     (s1_b_r),
    .flags_in (flags_r),
    .result   (alu_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= alu_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dest_index  = out_res_r.dest_index;
  assign out_dest_value  = out_res_r.dest_value;
  assign out_reg_written = out_res_r.reg_written;
  assign out_flag_n      = out_res_r.flags.n;
  assign out_flag_z      = out_res_r.flags.z;
  assign out_flag_c      = out_res_r.flags.c;
  assign out_flag_v      = out_res_r.flags.v;
  assign out_not_handled = out_res_r.not_handled;

  // checks
  `TAE_ASSERT(a_full_accept_drains, (in_xfer && s1_valid_r) |-> advance, "accept into full stage")
  `TAE_ASSERT_NEXT(a_advance_shows, advance, out_valid_r, "advanced item not presented")
  `TAE_ASSERT_NEXT(a_flags_hold, !advance, $stable(flags_r), "flags changed without an item")
  `TAE_ASSERT_NEXT(a_write_marks, wr_en, rf_valid_r[out_res_r.dest_index], "write not recorded")
  `TAE_ASSERT(a_unhandled_quiet, (out_valid_r && out_res_r.not_handled) |-> (!out_res_r.reg_written && out_res_r.dest_value == 32'd0), "unhandled opcode wrote")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tae_pkg::*;

  // expected-result tracker: mirrors the register file and flags of the stage
  class exec_tracker;
    logic [31:0] regs [8];
    flags_t      flags;
    alu_result_t pending_results [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned items_seen;
    int unsigned writes_seen;
    int unsigned unhandled_seen;

    function new();
      for (int i = 0; i < 8; i++) regs[i] = '0;
      flags = '0;
      mismatches = 0;
      results_seen = 0;
      items_seen = 0;
      writes_seen = 0;
      unhandled_seen = 0;
    endfunction

    function void set_nz(logic [31:0] v);
      flags.n = v[31];
      flags.z = (v == 32'd0);
    endfunction

    // a + b + cin with all four flags
    function logic [31:0] add_nzcv(logic [31:0] a, logic [31:0] b, logic cin);
      logic [32:0] wide;
      wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      flags.c = wide[32];
      flags.v = (wide[31] ^ a[31]) & (wide[31] ^ b[31]);
      set_nz(wide[31:0]);
      return wide[31:0];
    endfunction

    function logic [31:0] lsl(logic [31:0] v, int unsigned n);
      if (n == 0) return v;
      if (n < 32) begin
        flags.c = v[32 - n];
        return v << n;
      end
      flags.c = (n == 32) ? v[0] : 1'b0;
      return '0;
    endfunction

    function logic [31:0] lsr(logic [31:0] v, int unsigned n);
      if (n == 0) return v;
      if (n < 32) begin
        flags.c = v[n - 1];
        return v >> n;
      end
      flags.c = (n == 32) ? v[31] : 1'b0;
      return '0;
    endfunction

    function logic [31:0] asr(logic [31:0] v, int unsigned n);
      logic [31:0] r;
      if (n == 0) return v;
      if (n < 32) begin
        flags.c = v[n - 1];
        r = $signed(v) >>> n;
        return r;
      end
      flags.c = v[31];
      return {32{v[31]}};
    endfunction

    function logic [31:0] ror(logic [31:0] v, int unsigned n);
      int unsigned k;
      if (n == 0) return v;
      k = n % 32;
      if (k == 0) begin
        flags.c = v[31];
        return v;
      end
      flags.c = v[k - 1];
      return (v >> k) | (v << (32 - k));
    endfunction

    // work out the result of one accepted item and queue it
    function void note_item(logic kind, logic [15:0] op, logic [2:0] idx,
                            logic [31:0] wval);
      alu_result_t r;
      logic [31:0] a, b;
      logic        wr;
      logic        cin;
      int unsigned amt;
      r = '0;
      wr = 1'b0;
      items_seen++;
      if (kind) begin
        r.dest_index = idx;
        r.dest_value = wval;
        wr = 1'b1;
        writes_seen++;
      end else if (op[15:13] == FMT_SHIFT_ADDSUB) begin
        a = regs[op[5:3]];
        r.dest_index = op[2:0];
        wr = 1'b1;
        if (op[12:11] == SHIFT_ADDSUB) begin
          b = op[10] ? {29'd0, op[8:6]} : regs[op[8:6]];
          r.dest_value = op[9] ? add_nzcv(a, ~b, 1'b1) : add_nzcv(a, b, 1'b0);
        end else begin
          amt = op[10:6];
          case (shift_t'(op[12:11]))
            SH_LSL:  r.dest_value = lsl(a, amt);
            SH_LSR:  r.dest_value = lsr(a, (amt == 0) ? 32 : amt);
            default: r.dest_value = asr(a, (amt == 0) ? 32 : amt);
          endcase
          set_nz(r.dest_value);
        end
      end else if (op[15:13] == FMT_IMM8) begin
        r.dest_index = op[10:8];
        a = regs[op[10:8]];
        b = {24'd0, op[7:0]};
        case (imm_op_t'(op[12:11]))
          IMM_MOV: begin
            r.dest_value = b;
            set_nz(b);
            wr = 1'b1;
          end
          IMM_CMP: begin
            void'(add_nzcv(a, ~b, 1'b1));
            r.dest_value = a;
          end
          IMM_ADD: begin
            r.dest_value = add_nzcv(a, b, 1'b0);
            wr = 1'b1;
          end
          default: begin
            r.dest_value = add_nzcv(a, ~b, 1'b1);
            wr = 1'b1;
          end
        endcase
      end else if (op[15:10] == FMT_ALU) begin
        r.dest_index = op[2:0];
        a = regs[op[2:0]];
        b = regs[op[5:3]];
        amt = b[7:0];
        cin = flags.c;
        wr = 1'b1;
        r.dest_value = a;
        case (alu_op_t'(op[9:6]))
          ALU_AND: begin r.dest_value = a & b; set_nz(r.dest_value); end
          ALU_EOR: begin r.dest_value = a ^ b; set_nz(r.dest_value); end
          ALU_LSL: begin r.dest_value = lsl(a, amt); set_nz(r.dest_value); end
          ALU_LSR: begin r.dest_value = lsr(a, amt); set_nz(r.dest_value); end
          ALU_ASR: begin r.dest_value = asr(a, amt); set_nz(r.dest_value); end
          ALU_ADC: r.dest_value = add_nzcv(a, b, cin);
          ALU_SBC: r.dest_value = add_nzcv(a, ~b, cin);
          ALU_ROR: begin r.dest_value = ror(a, amt); set_nz(r.dest_value); end
          ALU_TST: begin set_nz(a & b); wr = 1'b0; end
          ALU_NEG: r.dest_value = add_nzcv(32'd0, ~b, 1'b1);
          ALU_CMP: begin void'(add_nzcv(a, ~b, 1'b1)); wr = 1'b0; end
          ALU_CMN: begin void'(add_nzcv(a, b, 1'b0)); wr = 1'b0; end
          ALU_ORR: begin r.dest_value = a | b; set_nz(r.dest_value); end
          ALU_MUL: begin r.dest_value = a * b; set_nz(r.dest_value); end
          ALU_BIC: begin r.dest_value = a & ~b; set_nz(r.dest_value); end
          default: begin r.dest_value = ~b; set_nz(r.dest_value); end
        endcase
      end else begin
        r.not_handled = 1'b1;
        unhandled_seen++;
      end
      if (wr) regs[r.dest_index] = r.dest_value;
      r.reg_written = wr;
      r.flags = flags;
      pending_results.push_back(r);
    endfunction

    // compare one transferred result against the oldest expectation
    function void check_result(alu_result_t got);
      alu_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing pending: rd=%0d val=%h", $realtime,
                   got.dest_index, got.dest_value);
        return;
      end
      want = pending_results.pop_front();
      if (got.dest_index !== want.dest_index || got.dest_value !== want.dest_value ||
          got.reg_written !== want.reg_written || got.flags.n !== want.flags.n ||
          got.flags.z !== want.flags.z || got.flags.c !== want.flags.c ||
          got.flags.v !== want.flags.v || got.not_handled !== want.not_handled) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] mismatch on result %0d", $realtime, results_seen);
          $display("  expected rd=%0d val=%h wr=%b nzcv=%b%b%b%b nh=%b",
                   want.dest_index, want.dest_value, want.reg_written, want.flags.n,
                   want.flags.z, want.flags.c, want.flags.v, want.not_handled);
          $display("  actual   rd=%0d val=%h wr=%b nzcv=%b%b%b%b nh=%b",
                   got.dest_index, got.dest_value, got.reg_written, got.flags.n,
                   got.flags.z, got.flags.c, got.flags.v, got.not_handled);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [15:0] in_instruction = '0;
  logic [2:0]  in_reg_index = '0;
  logic [31:0] in_write_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_dest_index;
  logic [31:0] out_dest_value;
  logic        out_reg_written;
  logic        out_flag_n;
  logic        out_flag_z;
  logic        out_flag_c;
  logic        out_flag_v;
  logic        out_not_handled;

  exec_tracker sb = new();

  int unsigned stall_left = 0;
  logic [1:0]  stall_mode = 2'd0;

  thumb_alu_execute DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_instruction  (in_instruction),
    .in_reg_index    (in_reg_index),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dest_index  (out_dest_index),
    .out_dest_value  (out_dest_value),
    .out_reg_written (out_reg_written),
    .out_flag_n      (out_flag_n),
    .out_flag_z      (out_flag_z),
    .out_flag_c      (out_flag_c),
    .out_flag_v      (out_flag_v),
    .out_not_handled (out_not_handled)
  );

  always #6 clk = ~clk;

  // opcode builders
  function automatic logic [15:0] enc_shift(shift_t sh, logic [4:0] amt, logic [2:0] rs,
                                            logic [2:0] rd);
    return {FMT_SHIFT_ADDSUB, sh, amt, rs, rd};
  endfunction

  function automatic logic [15:0] enc_addsub(logic imm, logic sub, logic [2:0] rn,
                                             logic [2:0] rs, logic [2:0] rd);
    return {FMT_SHIFT_ADDSUB, SHIFT_ADDSUB, imm, sub, rn, rs, rd};
  endfunction

  function automatic logic [15:0] enc_imm(imm_op_t o, logic [2:0] rd, logic [7:0] imm);
    return {FMT_IMM8, o, rd, imm};
  endfunction

  function automatic logic [15:0] enc_alu(alu_op_t o, logic [2:0] rs, logic [2:0] rd);
    return {FMT_ALU, o, rs, rd};
  endfunction

  // present one item and hold it until the stage takes it
  task automatic send_item(input logic kind, input logic [15:0] op, input logic [2:0] idx,
                           input logic [31:0] wval);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_instruction <= op;
    in_reg_index   <= idx;
    in_write_value <= wval;
    do @(posedge clk); while (in_stall);
  endtask

  // input transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_item(in_kind, in_instruction, in_reg_index, in_write_value);
  end

  // result transfers are checked
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(alu_result_t'({out_dest_index, out_dest_value, out_reg_written,
                                     out_flag_n, out_flag_z, out_flag_c, out_flag_v,
                                     out_not_handled}));
  end

  // receiver back-pressure: free, light, periodic or heavy, switched every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 99) < 30);
      2'd2:    out_stall <= stall_left[1];
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout: %0d results still pending", sb.pending_results.size());
    $display("** thumb_alu_execute: FAILED **");
    $finish;
  end

  initial begin
    logic [2:0]  rs_pick [4];
    logic        kind;
    logic [15:0] op;
    logic [2:0]  idx;
    logic [31:0] wval;
    int unsigned sel;
    int unsigned gap;
    int unsigned burst_left;
    rs_pick = '{3'd2, 3'd3, 3'd4, 3'd1};
    burst_left = 0;

    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: operand extremes
    send_item(1'b1, 16'h0000, 3'd1, 32'h8000_0000);
    send_item(1'b1, 16'h0000, 3'd2, 32'd32);
    send_item(1'b1, 16'h0000, 3'd3, 32'h0000_0100);
    send_item(1'b1, 16'h0000, 3'd4, 32'd33);
    send_item(1'b1, 16'h0000, 3'd7, 32'h7FFF_FFFF);
    // immediate shift of zero: lsl keeps carry, lsr/asr shift by 32
    send_item(1'b0, enc_shift(SH_LSL, 5'd0, 3'd1, 3'd5), 3'd0, 32'd0);
    send_item(1'b0, enc_shift(SH_LSR, 5'd0, 3'd1, 3'd5), 3'd0, 32'd0);
    send_item(1'b0, enc_shift(SH_ASR, 5'd0, 3'd1, 3'd6), 3'd0, 32'd0);
    // add with overflow, subtract immediate with borrow
    send_item(1'b0, enc_addsub(1'b0, 1'b0, 3'd7, 3'd7, 3'd5), 3'd0, 32'd0);
    send_item(1'b0, enc_addsub(1'b1, 1'b1, 3'd7, 3'd0, 3'd0), 3'd0, 32'd0);
    // 8-bit immediate ops
    send_item(1'b0, enc_imm(IMM_MOV, 3'd6, 8'hFF), 3'd0, 32'd0);
    send_item(1'b0, enc_imm(IMM_CMP, 3'd1, 8'h00), 3'd0, 32'd0);
    send_item(1'b0, enc_imm(IMM_ADD, 3'd6, 8'hFF), 3'd0, 32'd0);
    send_item(1'b0, enc_imm(IMM_SUB, 3'd7, 8'hFF), 3'd0, 32'd0);
    // every register alu op; shift amounts of 32, low byte zero, 33
    for (int j = 0; j < 16; j++)
      send_item(1'b0, enc_alu(alu_op_t'(j), rs_pick[j % 4], (j % 2 == 1) ? 3'd7 : 3'd1),
                3'd0, 32'd0);
    // unhandled opcodes
    send_item(1'b0, 16'hDF00, 3'd0, 32'd0);
    send_item(1'b0, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);

    // random: mostly handled formats, with direct writes to steer operands
    for (int i = 0; i < 650; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      kind = 1'b0;
      idx  = 3'($urandom);
      wval = $urandom;
      op   = 16'($urandom);
      sel  = $urandom_range(0, 99);
      if (sel < 22) begin
        kind = 1'b1;
        case ($urandom_range(0, 3))
          0: wval = $urandom_range(0, 40);
          1: begin
            case ($urandom_range(0, 4))
              0:       wval = 32'd0;
              1:       wval = 32'hFFFF_FFFF;
              2:       wval = 32'h8000_0000;
              3:       wval = 32'h7FFF_FFFF;
              default: wval = 32'd1;
            endcase
          end
          2: wval = ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 40);
          default: ;
        endcase
      end else if (sel < 37) begin
        op = enc_shift(shift_t'($urandom_range(0, 2)),
                       ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom),
                       3'($urandom), 3'($urandom));
      end else if (sel < 47) begin
        op = enc_addsub(1'($urandom), 1'($urandom), 3'($urandom), 3'($urandom),
                        3'($urandom));
      end else if (sel < 62) begin
        op = enc_imm(imm_op_t'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
      end else if (sel < 90) begin
        op = enc_alu(alu_op_t'($urandom_range(0, 15)), 3'($urandom), 3'($urandom));
      end
      send_item(kind, op, idx, wval);
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d items: %0d direct writes, %0d unhandled opcodes, rest executed",
             sb.items_seen, sb.writes_seen, sb.unhandled_seen);
    $display("checked %0d results, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("** thumb_alu_execute: PASSED **");
    end else begin
      $display("** thumb_alu_execute: FAILED **");
    end
    $finish;
  end

endmodule

@@ thumb_alu_execute.f @@
+incdir+rtl
rtl/tae_pkg.sv
rtl/tae_alu.sv
rtl/thumb_alu_execute.sv
verif/tb.sv
